// ===== rtl/secg_pkg.sv =====
// Constants, wave descriptors and lookup tables for the synthetic ECG sample generator.
package secg_pkg;

   localparam int EXP_TABLE_DEPTH  = 1024;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int WANDER_PERIOD    = 50000;

   localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam int SIN_IDX_W = $clog2(SINE_TABLE_DEPTH);

   localparam int SIN_IDX_SHIFT = 28;
   localparam int SIN_IDX_REC   =
      int'(((longint'(SINE_TABLE_DEPTH) << SIN_IDX_SHIFT) + longint'(WANDER_PERIOD) - 1)
           / longint'(WANDER_PERIOD));

   localparam int BPM_MIN        = 30;
   localparam int BPM_MAX        = 240;
   localparam int BPM_RESET      = 60;
   localparam int FACTOR_MIN     = 4096;
   localparam int ECG_BASE       = 2050;
   localparam int ECG_MAX        = 4095;
   localparam int CYC_NUM_SCALE  = 1875;
   localparam int WANDER_AMP     = 100;
   localparam int T_OFFSET       = 2560;
   localparam int REC_1000       = 1073742;
   localparam int REC_100        = 10737419;
   localparam int NUM_WAVES      = 7;

   localparam longint unsigned Q30_ONE    = 64'd1073741824;
   localparam longint unsigned EXP_SPAN   = 64'd8;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint          Q30_ONE_S  = 64'sd1073741824;

   typedef logic        [30:0] exp_rom_type [EXP_TABLE_DEPTH];
   typedef logic signed [31:0] sin_rom_type [SINE_TABLE_DEPTH];

   typedef struct packed {
      logic [9:0]  centre_k;
      logic [5:0]  width_k;
      logic [13:0] width_min;
      logic [9:0]  coef;
      logic        coef_neg;
      logic        group_end;
      logic        t_scale_en;
      logic [6:0]  t_scale;
      logic        offset_en;
      logic        offset_neg;
   } wave_type;

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type     tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned x3;
      longint unsigned x4;
      longint unsigned step;
      longint unsigned e;
      x    = (EXP_SPAN << 30) / EXP_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      x3   = (x2 * x) >> 30;
      x4   = (x3 * x) >> 30;
      step = Q30_ONE + x2 / 2 + x4 / 24 - x - x3 / 6;
      e    = Q30_ONE;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         tab[i] = e[30:0];
         e = (e * step) >> 30;
      end
      return tab;
   endfunction

   function automatic sin_rom_type build_sin_rom();
      sin_rom_type     tab;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned a3;
      longint unsigned a4;
      longint unsigned a5;
      longint          ca;
      longint          sa;
      longint          c;
      longint          s;
      longint          nc;
      longint          ns;
      a  = TWO_PI_Q30 / SINE_TABLE_DEPTH;
      a2 = (a * a) >> 30;
      a3 = (a2 * a) >> 30;
      a4 = (a3 * a) >> 30;
      a5 = (a4 * a) >> 30;
      ca = longint'(Q30_ONE - a2 / 2 + a4 / 24);
      sa = longint'(a - a3 / 6 + a5 / 120);
      c  = Q30_ONE_S;
      s  = 0;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         tab[i] = s[31:0];
         nc = (c * ca - s * sa) / Q30_ONE_S;
         ns = (s * ca + c * sa) / Q30_ONE_S;
         c  = nc;
         s  = ns;
      end
      return tab;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();
   localparam sin_rom_type SIN_ROM = build_sin_rom();

   function automatic wave_type wave_of(input logic [2:0] idx);
      wave_type w;
      w = '0;
      unique case (idx)
         3'd0: begin
            w.centre_k = 10'd180; w.width_k = 6'd22; w.width_min = 14'd4096;
            w.coef = 10'd70; w.group_end = 1'b1;
         end
         3'd1: begin
            w.centre_k = 10'd340; w.width_k = 6'd10; w.width_min = 14'd1408;
            w.coef = 10'd90; w.coef_neg = 1'b1;
         end
         3'd2: begin
            w.centre_k = 10'd360; w.width_k = 6'd8; w.width_min = 14'd1152;
            w.coef = 10'd880;
         end
         3'd3: begin
            w.centre_k = 10'd388; w.width_k = 6'd12; w.width_min = 14'd1920;
            w.coef = 10'd420; w.coef_neg = 1'b1;
         end
         3'd4: begin
            w.centre_k = 10'd440; w.width_k = 6'd30; w.width_min = 14'd5632;
            w.coef = 10'd25; w.group_end = 1'b1;
         end
         3'd5: begin
            w.centre_k = 10'd620; w.width_k = 6'd60; w.width_min = 14'd8192;
            w.coef = 10'd99; w.t_scale_en = 1'b1; w.t_scale = 7'd85;
            w.offset_en = 1'b1; w.offset_neg = 1'b1;
         end
         3'd6: begin
            w.centre_k = 10'd620; w.width_k = 6'd60; w.width_min = 14'd8192;
            w.coef = 10'd81; w.t_scale_en = 1'b1; w.t_scale = 7'd115;
            w.offset_en = 1'b1; w.group_end = 1'b1;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/synthetic_ecg_sample_generator.sv =====
// Synthetic ECG sample generator built around one shared multiplier and divider.
//
// Usage: the request channel (req_valid, req_stall, req_time_ms,
// req_variability_factor) carries one sample time per beat, and the response
// channel (rsp_valid, rsp_stall, rsp_ecg_value) returns one 12-bit sample per
// request beat, in order. The heart rate is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Values are clamped to 30..240 bpm. Each
// request runs two 40-step divisions on the shared restoring divider (cycle
// length and position in the cycle), a reciprocal multiply for the wander
// table index and seven Gaussian terms, each a chain of multiplies through the
// one shared multiplier plus a 10-step division; terms far from their centre
// skip the division. req_stall is high for the whole computation, so the next
// request is accepted only once the previous sample is finished. A finished
// sample waits in the response register while the next request is accepted;
// if the receiver still stalls when the next sample is done, the sequencer
// holds until the register is free. Synchronous reset sets the rate to 60 bpm,
// clears the wander phase, empties the response register and returns the
// sequencer to idle.
module synthetic_ecg_sample_generator
   import secg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_time_ms,
   input  logic [14:0] req_variability_factor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_ecg_value,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_CYC_MUL   = 5'd1;
   localparam logic [4:0] S_CYC_LD    = 5'd2;
   localparam logic [4:0] S_DIV       = 5'd3;
   localparam logic [4:0] S_X_LD      = 5'd4;
   localparam logic [4:0] S_SIN_MUL   = 5'd5;
   localparam logic [4:0] S_SIN_LD    = 5'd6;
   localparam logic [4:0] S_SIN_RD    = 5'd7;
   localparam logic [4:0] S_SIN_SCALE = 5'd8;
   localparam logic [4:0] S_SIN_ACC   = 5'd9;
   localparam logic [4:0] S_FR_MUL    = 5'd10;
   localparam logic [4:0] S_FR_REC    = 5'd11;
   localparam logic [4:0] S_FR_FIX    = 5'd12;
   localparam logic [4:0] S_DIST      = 5'd13;
   localparam logic [4:0] S_SQ        = 5'd14;
   localparam logic [4:0] S_CHK       = 5'd15;
   localparam logic [4:0] S_IDX_LD    = 5'd16;
   localparam logic [4:0] S_EXP_RD    = 5'd17;
   localparam logic [4:0] S_ACC_MUL   = 5'd18;
   localparam logic [4:0] S_ACC       = 5'd19;
   localparam logic [4:0] S_GRP       = 5'd20;
   localparam logic [4:0] S_OUT       = 5'd21;

   localparam logic [1:0] OP_MU    = 2'd0;
   localparam logic [1:0] OP_WIDTH = 2'd1;
   localparam logic [1:0] OP_SCALE = 2'd2;

   localparam logic [5:0] DIV_FULL_STEPS = 6'd40;

   logic [4:0]         state_ff, state_in;
   logic [4:0]         ret_ff, ret_in;
   logic [2:0]         g_ff, g_in;
   logic [1:0]         op_ff, op_in;
   logic [31:0]        tms_ff, tms_in;
   logic [14:0]        fac_ff, fac_in;
   logic [7:0]         bpm_ff, bpm_in;
   logic [15:0]        phase_ff, phase_in;
   logic [19:0]        cyc_ff, cyc_in;
   logic [19:0]        x_ff, x_in;
   logic [19:0]        mu_ff, mu_in;
   logic [16:0]        sig_ff, sig_in;
   logic [39:0]        d2_ff, d2_in;
   logic               gzero_ff, gzero_in;
   logic [29:0]        tmp_ff, tmp_in;
   logic [63:0]        prod_ff, prod_in;
   logic [37:0]        rem_ff, rem_in;
   logic [39:0]        num_ff, num_in;
   logic [19:0]        quo_ff, quo_in;
   logic [37:0]        div_ff, div_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [42:0] acc_ff, acc_in;
   logic signed [15:0] total_ff, total_in;
   logic [30:0]        exp_rd_ff;
   logic signed [31:0] sin_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        rsp_ecg_ff, rsp_ecg_in;

   wave_type           wv;
   logic [39:0]        mul_a;
   logic [23:0]        mul_b;
   logic [38:0]        div_t;
   logic [38:0]        div_diff;
   logic               div_ge;
   logic [19:0]        q0;
   logic [31:0]        q0c;
   logic [31:0]        cdiv;
   logic [19:0]        frac_q;
   logic [19:0]        d_abs;
   logic [31:0]        sin_mag;
   logic [37:0]        s2x16;
   logic signed [42:0] p43;
   logic signed [42:0] grp_sum;
   logic signed [12:0] grp_val;
   logic [7:0]         wander;
   logic [11:0]        ecg_sat;
   logic [16:0]        phase_inc;
   logic [52:0]        idx_num;

   assign wv        = wave_of(g_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ecg_value = rsp_ecg_ff;

   assign div_t    = {rem_ff, num_ff[39]};
   assign div_ge   = (div_t >= {1'b0, div_ff});
   assign div_diff = div_t - {1'b0, div_ff};

   assign cdiv   = (op_ff == OP_SCALE) ? 32'd100 : 32'd1000;
   assign q0     = prod_ff[49:30];
   assign q0c    = {12'd0, q0} * cdiv;
   assign frac_q = (q0c > {2'd0, tmp_ff}) ? q0 - 20'd1 : q0;

   assign d_abs   = (x_ff >= mu_ff) ? x_ff - mu_ff : mu_ff - x_ff;
   assign sin_mag = sin_rd_ff[31] ? 32'(-sin_rd_ff) : 32'(sin_rd_ff);
   assign s2x16   = {prod_ff[33:0], 4'd0};
   assign p43     = $signed({2'b00, prod_ff[40:0]});
   assign grp_sum = acc_ff + (acc_ff[42] ? 43'sd1073741823 : 43'sd0);
   assign grp_val = 13'(grp_sum >>> 30);
   assign wander  = prod_ff[37:30];
   assign idx_num = prod_ff[52:0];
   assign phase_inc = {1'b0, phase_ff} + 17'd1;

   always_comb begin
      if (total_ff[15]) begin
         ecg_sat = 12'd0;
      end else if (total_ff > 16'(ECG_MAX)) begin
         ecg_sat = 12'(ECG_MAX);
      end else begin
         ecg_sat = total_ff[11:0];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CYC_MUL: begin
            mul_a = 40'(fac_ff);
            mul_b = 24'(CYC_NUM_SCALE);
         end
         S_SIN_MUL: begin
            mul_a = 40'(phase_ff);
            mul_b = 24'(SIN_IDX_REC);
         end
         S_SIN_SCALE: begin
            mul_a = 40'(sin_mag);
            mul_b = 24'(WANDER_AMP);
         end
         S_FR_MUL: begin
            unique case (op_ff)
               OP_MU: begin
                  mul_a = 40'(cyc_ff);
                  mul_b = 24'(wv.centre_k);
               end
               OP_WIDTH: begin
                  mul_a = 40'(cyc_ff);
                  mul_b = 24'(wv.width_k);
               end
               default: begin
                  mul_a = 40'(sig_ff);
                  mul_b = 24'(wv.t_scale);
               end
            endcase
         end
         S_FR_REC: begin
            mul_a = 40'(prod_ff[29:0]);
            mul_b = (op_ff == OP_SCALE) ? 24'(REC_100) : 24'(REC_1000);
         end
         S_DIST: begin
            mul_a = 40'(d_abs);
            mul_b = 24'(d_abs);
         end
         S_SQ: begin
            mul_a = 40'(sig_ff);
            mul_b = 24'(sig_ff);
         end
         S_CHK: begin
            mul_a = d2_ff;
            mul_b = 24'(EXP_TABLE_DEPTH);
         end
         S_ACC_MUL: begin
            mul_a = gzero_ff ? 40'd0 : 40'(exp_rd_ff);
            mul_b = 24'(wv.coef);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = {24'd0, mul_a} * {40'd0, mul_b};

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      g_in         = g_ff;
      op_in        = op_ff;
      tms_in       = tms_ff;
      fac_in       = fac_ff;
      bpm_in       = bpm_ff;
      phase_in     = phase_ff;
      cyc_in       = cyc_ff;
      x_in         = x_ff;
      mu_in        = mu_ff;
      sig_in       = sig_ff;
      d2_in        = d2_ff;
      gzero_in     = gzero_ff;
      tmp_in       = tmp_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ecg_in   = rsp_ecg_ff;

      if (csr_wr_en) begin
         if (csr_wr_data < 8'(BPM_MIN)) begin
            bpm_in = 8'(BPM_MIN);
         end else if (csr_wr_data > 8'(BPM_MAX)) begin
            bpm_in = 8'(BPM_MAX);
         end else begin
            bpm_in = csr_wr_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tms_in   = req_time_ms;
               fac_in   = (req_variability_factor < 15'(FACTOR_MIN)) ?
                          15'(FACTOR_MIN) : req_variability_factor;
               state_in = S_CYC_MUL;
            end
         end
         S_CYC_MUL: begin
            state_in = S_CYC_LD;
         end
         S_CYC_LD: begin
            rem_in   = '0;
            num_in   = prod_ff[39:0];
            div_in   = 38'({bpm_ff, 1'b0});
            cnt_in   = DIV_FULL_STEPS;
            ret_in   = S_X_LD;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = div_ge ? div_diff[37:0] : div_t[37:0];
            num_in = {num_ff[38:0], 1'b0};
            quo_in = {quo_ff[18:0], div_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = ret_ff;
            end
         end
         S_X_LD: begin
            cyc_in   = quo_ff;
            rem_in   = '0;
            num_in   = {tms_ff, 8'd0};
            div_in   = 38'(quo_ff);
            cnt_in   = DIV_FULL_STEPS;
            ret_in   = S_SIN_MUL;
            state_in = S_DIV;
         end
         S_SIN_MUL: begin
            x_in     = rem_ff[19:0];
            state_in = S_SIN_LD;
         end
         S_SIN_LD: begin
            quo_in   = 20'(prod_ff[SIN_IDX_SHIFT +: SIN_IDX_W]);
            state_in = S_SIN_RD;
         end
         S_SIN_RD: begin
            state_in = S_SIN_SCALE;
         end
         S_SIN_SCALE: begin
            state_in = S_SIN_ACC;
         end
         S_SIN_ACC: begin
            total_in = sin_rd_ff[31] ? 16'sd2050 - $signed(16'(wander)) :
                                       16'sd2050 + $signed(16'(wander));
            acc_in   = '0;
            g_in     = '0;
            op_in    = OP_MU;
            state_in = S_FR_MUL;
         end
         S_FR_MUL: begin
            state_in = S_FR_REC;
         end
         S_FR_REC: begin
            tmp_in   = prod_ff[29:0];
            state_in = S_FR_FIX;
         end
         S_FR_FIX: begin
            unique case (op_ff)
               OP_MU: begin
                  if (wv.offset_en && wv.offset_neg) begin
                     mu_in = frac_q - 20'(T_OFFSET);
                  end else if (wv.offset_en) begin
                     mu_in = frac_q + 20'(T_OFFSET);
                  end else begin
                     mu_in = frac_q;
                  end
                  op_in    = OP_WIDTH;
                  state_in = S_FR_MUL;
               end
               OP_WIDTH: begin
                  sig_in = (frac_q > 20'(wv.width_min)) ? frac_q[16:0] :
                                                          17'(wv.width_min);
                  if (wv.t_scale_en) begin
                     op_in    = OP_SCALE;
                     state_in = S_FR_MUL;
                  end else begin
                     state_in = S_DIST;
                  end
               end
               default: begin
                  sig_in   = frac_q[16:0];
                  state_in = S_DIST;
               end
            endcase
         end
         S_DIST: begin
            state_in = S_SQ;
         end
         S_SQ: begin
            d2_in    = prod_ff[39:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            gzero_in = (d2_ff >= s2x16);
            div_in   = s2x16;
            state_in = (d2_ff >= s2x16) ? S_ACC_MUL : S_IDX_LD;
         end
         S_IDX_LD: begin
            rem_in   = 38'(idx_num >> EXP_IDX_W);
            num_in   = 40'(idx_num[EXP_IDX_W-1:0]) << (40 - EXP_IDX_W);
            cnt_in   = 6'(EXP_IDX_W);
            ret_in   = S_EXP_RD;
            state_in = S_DIV;
         end
         S_EXP_RD: begin
            state_in = S_ACC_MUL;
         end
         S_ACC_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = wv.coef_neg ? acc_ff - p43 : acc_ff + p43;
            if (wv.group_end) begin
               state_in = S_GRP;
            end else begin
               g_in     = g_ff + 3'd1;
               op_in    = OP_MU;
               state_in = S_FR_MUL;
            end
         end
         S_GRP: begin
            total_in = total_ff + 16'(grp_val);
            acc_in   = '0;
            if (g_ff == 3'(NUM_WAVES - 1)) begin
               state_in = S_OUT;
            end else begin
               g_in     = g_ff + 3'd1;
               op_in    = OP_MU;
               state_in = S_FR_MUL;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ecg_in   = ecg_sat;
               phase_in     = (phase_inc >= 17'(WANDER_PERIOD)) ? 16'd0 : phase_inc[15:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      exp_rd_ff <= EXP_ROM[quo_ff[EXP_IDX_W-1:0]];
      sin_rd_ff <= SIN_ROM[quo_ff[SIN_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bpm_ff       <= 8'(BPM_RESET);
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bpm_ff       <= bpm_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      g_ff       <= g_in;
      op_ff      <= op_in;
      tms_ff     <= tms_in;
      fac_ff     <= fac_in;
      cyc_ff     <= cyc_in;
      x_ff       <= x_in;
      mu_ff      <= mu_in;
      sig_ff     <= sig_in;
      d2_ff      <= d2_in;
      gzero_ff   <= gzero_in;
      tmp_ff     <= tmp_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      div_ff     <= div_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      total_ff   <= total_in;
      rsp_ecg_ff <= rsp_ecg_in;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_CYC_MUL)
      else $error("Accepted request beat did not start the computation.");

   a_bpm_range: assert property (@(posedge clock) disable iff (reset)
      bpm_ff >= 8'(BPM_MIN) && bpm_ff <= 8'(BPM_MAX))
      else $error("Heart rate register left its clamped range.");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < 16'(WANDER_PERIOD))
      else $error("Wander phase reached its period.");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff != 6'd0)
      else $error("Divider running with an empty step count.");

   a_out_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && !rsp_stall |=> rsp_valid && state_ff == S_IDLE)
      else $error("Finished sample was not moved into the response register.");
`endif

endmodule
